// ===== design/tap_tempo_estimator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Tap tempo estimator: assertion macros
// Shared concurrent-assertion shorthands. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_ESTIMATOR_UNIT_DEFINES_SVH
`define TAP_TEMPO_ESTIMATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// Tap tempo estimator package
// Fixed constants of the tempo and steadiness arithmetic.
// ----------------------------------------------------------------------------
package tte_pkg;

    // Milliseconds in one minute.
    localparam int unsigned MS_PER_MINUTE = 60000;

    // Saturation value of the tempo output.
    localparam logic [15:0] TEMPO_MAX = 16'hFFFF;

    // Field widths of the stream payloads.
    localparam int unsigned TAP_TIME_W = 32;
    localparam int unsigned TEMPO_W    = 16;
    localparam int unsigned OUT_DATA_W = 24;

endpackage

// ===== design/tap_tempo_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// Tap tempo estimator
// Turns tap timestamps into a moving-average tempo and a steadiness flag.
// ----------------------------------------------------------------------------
// Each input beat is one tap carrying a free-running millisecond timestamp.
// The interval to the previous tap (modulo 2^32, measured from time 0 after
// reset) is pushed into a window of the last WINDOW_LEN intervals, and one
// output beat follows with tempo_bpm = floor(60000 * WINDOW_LEN / sum of the
// window), saturated at 65535 (also for a zero sum), and steady, set when the
// shortest interval times ten exceeds the longest times nine. One tap is
// processed at a time: after a tap is accepted, the sum drops the oldest
// interval and adds the new one, a min/max scan visits one window entry per
// cycle, the extremes are scaled and compared, and a restoring divider
// produces one quotient bit per cycle for Q = clog2(60000 * WINDOW_LEN + 1)
// quotient bits (18 at the default length) before the result beat is
// offered; the next tap is accepted only after that. A finished result waits
// in the output register while the next tap is accepted; a further result is
// held back until the register is free.
`include "tap_tempo_estimator_unit_defines.svh"

module tap_tempo_estimator_unit
    import tte_pkg::*;
#(
    parameter int WINDOW_LEN = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Tap stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TAP_TIME_W-1:0] s_tdata,   // [31:0] tap_time_ms
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [15:0] tempo_bpm, [16] steady, rest zero
);

    localparam int IDX_W   = $clog2(WINDOW_LEN);
    localparam int SUM_W   = TAP_TIME_W + IDX_W;
    localparam int NUM_W   = $clog2(MS_PER_MINUTE * WINDOW_LEN + 1);
    localparam int CNT_W   = $clog2(NUM_W);
    localparam int SCALE_W = TAP_TIME_W + 4;
    localparam logic [NUM_W-1:0] NUMERATOR = NUM_W'(MS_PER_MINUTE * WINDOW_LEN);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_SCAN,
        ST_SCALE,
        ST_CMP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [TAP_TIME_W-1:0]   last_time_reg;
    logic [TAP_TIME_W-1:0]   window_reg [WINDOW_LEN];
    logic [TAP_TIME_W-1:0]   oldest_reg;
    logic [TAP_TIME_W-1:0]   delta_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [IDX_W-1:0]        scan_idx_reg;
    logic [TAP_TIME_W-1:0]   lo_reg;
    logic [TAP_TIME_W-1:0]   hi_reg;
    logic [SCALE_W-1:0]      lo10_reg;
    logic [SCALE_W-1:0]      hi9_reg;
    logic                    steady_calc_reg;
    logic [SUM_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [NUM_W-1:0]        quot_reg;
    logic [CNT_W-1:0]        div_cnt_reg;
    logic                    out_valid_reg;
    logic [TEMPO_W-1:0]      tempo_reg;
    logic                    steady_reg;

    logic [TAP_TIME_W-1:0]   delta_next;
    logic [TAP_TIME_W-1:0]   scan_val;
    logic [SUM_W:0]          rem_trial;
    logic                    rem_fits;
    logic [SUM_W:0]          rem_next;
    logic [TEMPO_W-1:0]      tempo_next;

    // Handshake signals and output payload.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - TEMPO_W - 1){1'b0}}, steady_reg, tempo_reg};

    // Interval since the previous tap, wrapping modulo 2^32.
    assign delta_next = s_tdata - last_time_reg;

    // Window entry visited by the min/max scan.
    assign scan_val = window_reg[scan_idx_reg];

    // One restoring division step: bring down the next numerator bit and
    // subtract the divisor when it fits. A zero divisor always fits, so the
    // quotient comes out all ones and saturates below.
    assign rem_trial = {rem_reg, num_reg[NUM_W-1]};
    assign rem_fits  = (rem_trial >= {1'b0, sum_reg});
    assign rem_next  = rem_fits ? (rem_trial - {1'b0, sum_reg}) : rem_trial;

    // Saturate the quotient to the output width.
    assign tempo_next = (quot_reg[NUM_W-1:TEMPO_W] != '0) ? TEMPO_MAX
                                                          : quot_reg[TEMPO_W-1:0];

    // Sequencer, datapath registers and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_time_reg   <= '0;
            sum_reg         <= '0;
            out_valid_reg   <= 1'b0;
            oldest_reg      <= '0;
            delta_reg       <= '0;
            scan_idx_reg    <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            lo10_reg        <= '0;
            hi9_reg         <= '0;
            steady_calc_reg <= 1'b0;
            rem_reg         <= '0;
            num_reg         <= '0;
            quot_reg        <= '0;
            div_cnt_reg     <= '0;
            tempo_reg       <= '0;
            steady_reg      <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            // A waiting result leaves when the sink takes it, unless a new
            // result is loaded in the same cycle.
            if (out_valid_reg && m_tready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        delta_reg     <= delta_next;
                        oldest_reg    <= window_reg[0];
                        last_time_reg <= s_tdata;
                        for (int i = 0; i < WINDOW_LEN - 1; i++)
                        begin
                            window_reg[i] <= window_reg[i + 1];
                        end
                        window_reg[WINDOW_LEN - 1] <= delta_next;
                        state_reg <= ST_SUB;
                    end
                end

                ST_SUB:
                begin
                    sum_reg   <= sum_reg - SUM_W'(oldest_reg);
                    state_reg <= ST_ADD;
                end

                ST_ADD:
                begin
                    sum_reg      <= sum_reg + SUM_W'(delta_reg);
                    lo_reg       <= window_reg[0];
                    hi_reg       <= window_reg[0];
                    scan_idx_reg <= IDX_W'(1);
                    state_reg    <= ST_SCAN;
                end

                ST_SCAN:
                begin
                    if (scan_val < lo_reg)
                    begin
                        lo_reg <= scan_val;
                    end
                    if (scan_val > hi_reg)
                    begin
                        hi_reg <= scan_val;
                    end
                    if (scan_idx_reg == IDX_W'(WINDOW_LEN - 1))
                    begin
                        state_reg <= ST_SCALE;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    end
                end

                ST_SCALE:
                begin
                    // Shortest times ten and longest times nine, by shifts and adds.
                    lo10_reg  <= {1'b0, lo_reg, 3'b000} + {3'b000, lo_reg, 1'b0};
                    hi9_reg   <= {1'b0, hi_reg, 3'b000} + {4'b0000, hi_reg};
                    state_reg <= ST_CMP;
                end

                ST_CMP:
                begin
                    steady_calc_reg <= (hi_reg != '0) && (lo10_reg > hi9_reg);
                    rem_reg         <= '0;
                    num_reg         <= NUMERATOR;
                    quot_reg        <= '0;
                    div_cnt_reg     <= '0;
                    state_reg       <= ST_DIV;
                end

                ST_DIV:
                begin
                    rem_reg  <= rem_next[SUM_W-1:0];
                    num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                    quot_reg <= {quot_reg[NUM_W-2:0], rem_fits};
                    if (div_cnt_reg == CNT_W'(NUM_W - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg + CNT_W'(1);
                    end
                end

                ST_DONE:
                begin
                    // Load the output register once it is free or being emptied.
                    if (!out_valid_reg || m_tready)
                    begin
                        tempo_reg     <= tempo_next;
                        steady_reg    <= steady_calc_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks on the sequencer and the arithmetic.
    `TTE_ASSERT_NEXT(a_accept_starts_update,
        s_tvalid && s_tready,
        state_reg == ST_SUB,
        "Accepted tap did not start the window update")
    `TTE_ASSERT_SAME(a_rem_below_divisor,
        (state_reg == ST_DIV) && (sum_reg != '0),
        rem_reg < sum_reg,
        "Division remainder reached the divisor")
    `TTE_ASSERT_SAME(a_zero_sum_saturates,
        out_valid_reg && (state_reg == ST_IDLE) && (sum_reg == '0),
        tempo_reg == TEMPO_MAX,
        "Zero interval sum did not give the saturated tempo")
    `TTE_ASSERT_SAME(a_steady_needs_interval,
        out_valid_reg && steady_reg && (state_reg == ST_IDLE),
        lo_reg != '0,
        "Steady flag set with a zero shortest interval")

endmodule
